// File: hdl/msfd_pkg.sv
// Shared types, constants and helpers of the multi-server FCFS dispatcher.
// Used by msfd_ctrl, msfd_dp and the top level multi_server_fcfs_dispatcher.
// No dependencies.
package msfd_pkg;

  // Server pool size. The minimum search tree assumes a multiple of eight.
  localparam int SRV_NUM   = 16;
  localparam int SRV_IDX_W = $clog2(SRV_NUM);
  localparam int SRV_CNT_W = $clog2(SRV_NUM + 1);

  // Field widths.
  localparam int TIME_W = 20;
  localparam int SVC_W  = 8;
  localparam int CNT_W  = 16;
  localparam int SUM_W  = 32;

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_COUNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_CAP  = 1'b1;

  localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 5'd1;
  localparam logic [SVC_W-1:0]       CAP_RESET   = 8'd60;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch an accepted job
    logic srch1;    // free test and first level of the minimum tree
    logic srch2;    // two more tree levels
    logic srch3;    // final pick, start and wait
    logic commit;   // update server state and statistics, load result
  } msfd_cmd_t;

  // One candidate in the earliest-finish search.
  typedef struct packed {
    logic                 vld;
    logic [SRV_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    val;
  } msfd_cand_t;

  // Keeps the lower-indexed candidate a unless b is valid and strictly earlier.
  function automatic msfd_cand_t cand_min(input msfd_cand_t a, input msfd_cand_t b);
    msfd_cand_t r;
    if (b.vld && (!a.vld || (b.val < a.val))) begin
      r = b;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

// File: hdl/msfd_ctrl.sv
// Controller of the multi-server FCFS dispatcher: job sequencing and the
// result valid flag. Depends on msfd_pkg.
module msfd_ctrl import msfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output msfd_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_S1;
        end
      end
      ST_S1: begin
        cmd.srch1 = 1'b1;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        cmd.srch2 = 1'b1;
        state_nxt = ST_S3;
      end
      ST_S3: begin
        cmd.srch3 = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid: set by a commit, cleared by an output transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  // An accepted job always starts the search in the next cycle.
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_S1))
    else $error("accepted job did not enter the search");

  // A commit always presents a result in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("commit without a valid result");

  // A commit never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // The search stages run without pause.
  a_search_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_S2) |=> (state_r == ST_S3))
    else $error("search stage skipped or held");
`endif

endmodule

// File: hdl/msfd_dp.sv
// Datapath of the multi-server FCFS dispatcher: configuration registers,
// server state, staged server search, statistics and result register.
// Depends on msfd_pkg.
module msfd_dp import msfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msfd_cmd_t              cmd,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [TIME_W-1:0]      in_arrival_time,
  input  logic [SVC_W-1:0]       in_service_time,
  output logic [SRV_IDX_W-1:0]   out_server_index,
  output logic [TIME_W-1:0]      out_wait_time,
  output logic [TIME_W-1:0]      out_finish_time,
  output logic [CNT_W-1:0]       out_server_jobs,
  output logic [SUM_W-1:0]       out_total_wait,
  output logic [TIME_W-1:0]      out_longest_wait,
  output logic [TIME_W-1:0]      out_latest_finish,
  output logic [CNT_W-1:0]       out_jobs_so_far,
  output logic                   out_overflow
);

  localparam int L1_NUM = SRV_NUM / 2;

  // Configuration registers.
  logic [CFG_COUNT_W-1:0] cfg_count_r;
  logic [SVC_W-1:0]       cfg_cap_r;

  // Current job.
  logic [TIME_W-1:0]    arr_r;
  logic [SVC_W-1:0]     svc_r, svc_nxt;
  logic [SRV_CNT_W-1:0] n_r, n_nxt;

  // Per-server state.
  logic [TIME_W-1:0] free_at_r [SRV_NUM];
  logic [CNT_W-1:0]  served_r  [SRV_NUM];

  // Running statistics.
  logic [SUM_W-1:0]  wait_sum_r;
  logic [TIME_W-1:0] wait_peak_r, finish_peak_r;
  logic [CNT_W-1:0]  job_count_r;
  logic              sat_r;

  // Search pipeline.
  logic [SRV_NUM-1:0]   free_vec;
  logic                 found_r;
  logic [SRV_IDX_W-1:0] first_r, first_nxt;
  msfd_cand_t           lvl1_r [L1_NUM];
  msfd_cand_t           lvl1_nxt [L1_NUM];
  msfd_cand_t           lvl2_r [2];
  msfd_cand_t           lvl2_nxt [2];
  msfd_cand_t           best;
  logic [SRV_IDX_W-1:0] pick_r, pick_nxt;
  logic [TIME_W-1:0]    start_r, start_nxt;
  logic [TIME_W-1:0]    wait_r;

  // Commit arithmetic.
  logic [TIME_W:0]    fin_sum;
  logic [TIME_W-1:0]  fin;
  logic               fin_ovf;
  logic [CNT_W-1:0]   served_pick, served_nxt;
  logic               served_full;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   wait_sum_nxt;
  logic               sum_ovf;
  logic [CNT_W-1:0]   job_count_nxt;
  logic               jobs_full;
  logic [TIME_W-1:0]  wait_peak_nxt, finish_peak_nxt;
  logic               sat_nxt;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= COUNT_RESET;
      cfg_cap_r   <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SERVER_COUNT: cfg_count_r <= cfg_wdata[CFG_COUNT_W-1:0];
        CFG_SERVICE_CAP:  cfg_cap_r   <= cfg_wdata[SVC_W-1:0];
        default: ;
      endcase
    end
  end

  // Job intake: clamp the service time and the active server count.
  always_comb begin
    svc_nxt = (in_service_time > cfg_cap_r) ? cfg_cap_r : in_service_time;
    if (cfg_count_r == '0) begin
      n_nxt = SRV_CNT_W'(1);
    end else if (cfg_count_r > SRV_NUM) begin
      n_nxt = SRV_CNT_W'(SRV_NUM);
    end else begin
      n_nxt = SRV_CNT_W'(cfg_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r <= in_arrival_time;
      svc_r <= svc_nxt;
      n_r   <= n_nxt;
    end
  end

  // Stage one: which active servers are free, the first of them, and the
  // first level of the earliest-finish tree.
  always_comb begin
    for (int i = 0; i < SRV_NUM; i++) begin
      free_vec[i] = (SRV_CNT_W'(i) < n_r) && (free_at_r[i] <= arr_r);
    end
    first_nxt = '0;
    for (int i = SRV_NUM - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first_nxt = SRV_IDX_W'(i);
      end
    end
    for (int j = 0; j < L1_NUM; j++) begin
      lvl1_nxt[j] = cand_min(
        '{vld: (SRV_CNT_W'(2 * j) < n_r), idx: SRV_IDX_W'(2 * j), val: free_at_r[2 * j]},
        '{vld: (SRV_CNT_W'(2 * j + 1) < n_r), idx: SRV_IDX_W'(2 * j + 1),
          val: free_at_r[2 * j + 1]});
    end
  end

  // Stage two: two more tree levels, down to two candidates.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      lvl2_nxt[k] = lvl1_r[k * (L1_NUM / 2)];
      for (int m = 1; m < L1_NUM / 2; m++) begin
        lvl2_nxt[k] = cand_min(lvl2_nxt[k], lvl1_r[k * (L1_NUM / 2) + m]);
      end
    end
  end

  // Stage three: final pick, start of service and wait.
  always_comb begin
    best      = cand_min(lvl2_r[0], lvl2_r[1]);
    pick_nxt  = found_r ? first_r : best.idx;
    start_nxt = found_r ? arr_r : best.val;
  end

  always_ff @(posedge clk) begin
    if (cmd.srch1) begin
      found_r <= |free_vec;
      first_r <= first_nxt;
      for (int j = 0; j < L1_NUM; j++) begin
        lvl1_r[j] <= lvl1_nxt[j];
      end
    end
    if (cmd.srch2) begin
      lvl2_r[0] <= lvl2_nxt[0];
      lvl2_r[1] <= lvl2_nxt[1];
    end
    if (cmd.srch3) begin
      pick_r  <= pick_nxt;
      start_r <= start_nxt;
      wait_r  <= start_nxt - arr_r;
    end
  end

  // Commit: finish time, counters and statistics, all saturating.
  always_comb begin
    fin_sum     = {1'b0, start_r} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_r};
    fin_ovf     = fin_sum[TIME_W];
    fin         = fin_ovf ? TIME_MAX : fin_sum[TIME_W-1:0];

    served_pick = served_r[pick_r];
    served_full = (served_pick == CNT_MAX);
    served_nxt  = served_full ? served_pick : served_pick + 1'b1;

    sum_ext      = {1'b0, wait_sum_r} + {{(SUM_W + 1 - TIME_W){1'b0}}, wait_r};
    sum_ovf      = sum_ext[SUM_W];
    wait_sum_nxt = sum_ovf ? SUM_MAX : sum_ext[SUM_W-1:0];

    jobs_full     = (job_count_r == CNT_MAX);
    job_count_nxt = jobs_full ? job_count_r : job_count_r + 1'b1;

    wait_peak_nxt   = (wait_r > wait_peak_r) ? wait_r : wait_peak_r;
    finish_peak_nxt = (fin > finish_peak_r) ? fin : finish_peak_r;

    sat_nxt = sat_r | fin_ovf | served_full | sum_ovf | jobs_full;
  end

  // Server and statistics state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SRV_NUM; i++) begin
        free_at_r[i] <= '0;
        served_r[i]  <= '0;
      end
      wait_sum_r    <= '0;
      wait_peak_r   <= '0;
      finish_peak_r <= '0;
      job_count_r   <= '0;
      sat_r         <= 1'b0;
    end else if (cmd.commit) begin
      free_at_r[pick_r] <= fin;
      served_r[pick_r]  <= served_nxt;
      wait_sum_r        <= wait_sum_nxt;
      wait_peak_r       <= wait_peak_nxt;
      finish_peak_r     <= finish_peak_nxt;
      job_count_r       <= job_count_nxt;
      sat_r             <= sat_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_server_index  <= pick_r;
      out_wait_time     <= wait_r;
      out_finish_time   <= fin;
      out_server_jobs   <= served_nxt;
      out_total_wait    <= wait_sum_nxt;
      out_longest_wait  <= wait_peak_nxt;
      out_latest_finish <= finish_peak_nxt;
      out_jobs_so_far   <= job_count_nxt;
      out_overflow      <= sat_nxt;
    end
  end

`ifndef ASSERT_OFF
  // A free server found in stage one means no wait.
  a_free_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.srch3 && found_r) |=> (wait_r == '0))
    else $error("job waited although a server was free");

  // The chosen server is always one of the active ones.
  a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (SRV_CNT_W'(pick_r) < n_r))
    else $error("job sent to an inactive server");

  // The overflow flag never clears once set.
  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |=> sat_r)
    else $error("overflow flag cleared");
`endif

endmodule

// File: hdl/multi_server_fcfs_dispatcher.sv
// Top level of the multi-server FCFS dispatcher.
// Depends on msfd_pkg, msfd_ctrl and msfd_dp.
//
// Usage: jobs enter on the in_ channel (arrival time, requested service time)
// as valid/stall transfers, in arrival order. Each job yields one result on
// the out_ channel: chosen server, wait, finish time, that server's job count
// and the running wait, finish and job statistics with a sticky overflow flag.
// The cfg_ port writes the active server count (index 0) and the service cap
// (index 1); write it only while no job is in flight.
// A result is registered at commit, which follows the search states S1, S2 and S3.
// A job is taken only while the block is idle; the next job is taken in the cycle
// after the previous one commits. The pace is set by the staged search over
// the sixteen server finish times (free test with the first tree level, two more
// levels, final pick) and the commit step that updates the chosen server.
// A stalled result holds in the output register; a following job runs its
// search meanwhile and waits at commit until the result is taken.
// Reset (synchronous, active low) clears all server times, counts and
// statistics, sets one active server and a cap of 60 minutes.
module multi_server_fcfs_dispatcher import msfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TIME_W-1:0]      in_arrival_time,
  input  logic [SVC_W-1:0]       in_service_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SRV_IDX_W-1:0]   out_server_index,
  output logic [TIME_W-1:0]      out_wait_time,
  output logic [TIME_W-1:0]      out_finish_time,
  output logic [CNT_W-1:0]       out_server_jobs,
  output logic [SUM_W-1:0]       out_total_wait,
  output logic [TIME_W-1:0]      out_longest_wait,
  output logic [TIME_W-1:0]      out_latest_finish,
  output logic [CNT_W-1:0]       out_jobs_so_far,
  output logic                   out_overflow
);

  msfd_cmd_t cmd;

  // Sequencing and handshakes.
  msfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // State, search and statistics.
  msfd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_arrival_time   (in_arrival_time),
    .in_service_time   (in_service_time),
    .out_server_index  (out_server_index),
    .out_wait_time     (out_wait_time),
    .out_finish_time   (out_finish_time),
    .out_server_jobs   (out_server_jobs),
    .out_total_wait    (out_total_wait),
    .out_longest_wait  (out_longest_wait),
    .out_latest_finish (out_latest_finish),
    .out_jobs_so_far   (out_jobs_so_far),
    .out_overflow      (out_overflow)
  );

endmodule

// File: dv/dispatch_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-server FCFS dispatcher: it watches cfg_ writes and the in_/out_
// transfers, predicts every dispatch and compares it field by field. Depends on msfd_pkg.
module dispatch_checker import msfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [TIME_W-1:0]     in_arrival_time,
  input  logic [SVC_W-1:0]      in_service_time,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [SRV_IDX_W-1:0]  out_server_index,
  input  logic [TIME_W-1:0]     out_wait_time,
  input  logic [TIME_W-1:0]     out_finish_time,
  input  logic [CNT_W-1:0]      out_server_jobs,
  input  logic [SUM_W-1:0]      out_total_wait,
  input  logic [TIME_W-1:0]     out_longest_wait,
  input  logic [TIME_W-1:0]     out_latest_finish,
  input  logic [CNT_W-1:0]      out_jobs_so_far,
  input  logic                  out_overflow,
  output int                    dispatches_pending,
  output int                    mismatch_count
);

  typedef struct packed {
    logic [SRV_IDX_W-1:0] server_index;
    logic [TIME_W-1:0]    wait_time;
    logic [TIME_W-1:0]    finish_time;
    logic [CNT_W-1:0]     server_jobs;
    logic [SUM_W-1:0]     total_wait;
    logic [TIME_W-1:0]    longest_wait;
    logic [TIME_W-1:0]    latest_finish;
    logic [CNT_W-1:0]     jobs_so_far;
    logic                 overflow;
  } dispatch_result_t;

  // Shadow copy of the registers and of the server and statistics state.
  logic [CFG_COUNT_W-1:0] active_servers;
  logic [SVC_W-1:0]       service_cap;
  logic [TIME_W-1:0]      free_at [SRV_NUM];
  logic [CNT_W-1:0]       served [SRV_NUM];
  logic [SUM_W-1:0]       wait_total;
  logic [TIME_W-1:0]      wait_max;
  logic [TIME_W-1:0]      finish_max;
  logic [CNT_W-1:0]       job_total;
  logic                   sticky_ovf;

  dispatch_result_t predicted_dispatches[$];
  int mismatches = 0;

  assign mismatch_count = mismatches;

  // Places one job on a server and updates the shadow state, as the block should.
  function automatic dispatch_result_t dispatch_job(input logic [TIME_W-1:0] arrival,
                                                    input logic [SVC_W-1:0] request);
    int n;
    int i;
    int pick;
    bit found;
    logic [SVC_W-1:0]  svc;
    logic [TIME_W-1:0] start;
    logic [TIME_W:0]   fin_wide;
    logic [SUM_W:0]    sum_wide;
    dispatch_result_t  r;
    n = int'(active_servers);
    if (n == 0) begin
      n = 1;
    end else if (n > SRV_NUM) begin
      n = SRV_NUM;
    end
    svc = (request > service_cap) ? service_cap : request;

    // Lowest-numbered server that is free at the arrival.
    found = 1'b0;
    pick = 0;
    for (i = 0; i < n; i++) begin
      if (!found && free_at[i] <= arrival) begin
        pick = i;
        found = 1'b1;
      end
    end
    // Otherwise the earliest finish, the lower index winning a tie.
    if (!found) begin
      for (i = 1; i < n; i++) begin
        if (free_at[i] < free_at[pick]) begin
          pick = i;
        end
      end
    end

    start = found ? arrival : free_at[pick];
    r.wait_time = start - arrival;
    fin_wide = (TIME_W+1)'(start) + (TIME_W+1)'(svc);
    if (fin_wide > (TIME_W+1)'(TIME_MAX)) begin
      fin_wide = (TIME_W+1)'(TIME_MAX);
      sticky_ovf = 1'b1;
    end
    r.finish_time = fin_wide[TIME_W-1:0];
    free_at[pick] = r.finish_time;

    if (served[pick] != CNT_MAX) begin
      served[pick] = served[pick] + 1'b1;
    end else begin
      sticky_ovf = 1'b1;
    end

    sum_wide = (SUM_W+1)'(wait_total) + (SUM_W+1)'(r.wait_time);
    if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      wait_total = SUM_MAX;
      sticky_ovf = 1'b1;
    end else begin
      wait_total = sum_wide[SUM_W-1:0];
    end
    if (r.wait_time > wait_max) begin
      wait_max = r.wait_time;
    end
    if (r.finish_time > finish_max) begin
      finish_max = r.finish_time;
    end
    if (job_total != CNT_MAX) begin
      job_total = job_total + 1'b1;
    end else begin
      sticky_ovf = 1'b1;
    end

    r.server_index  = SRV_IDX_W'(pick);
    r.server_jobs   = served[pick];
    r.total_wait    = wait_total;
    r.longest_wait  = wait_max;
    r.latest_finish = finish_max;
    r.jobs_so_far   = job_total;
    r.overflow      = sticky_ovf;
    return r;
  endfunction

  // Compares one field and reports any difference.
  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Results are taken before the prediction of a job that transfers at the same edge,
  // since a result always belongs to an older job.
  always @(posedge clk) begin
    dispatch_result_t want;
    if (!rst_n) begin
      active_servers = COUNT_RESET;
      service_cap = CAP_RESET;
      for (int s = 0; s < SRV_NUM; s++) begin
        free_at[s] = '0;
        served[s] = '0;
      end
      wait_total = '0;
      wait_max = '0;
      finish_max = '0;
      job_total = '0;
      sticky_ovf = 1'b0;
      predicted_dispatches.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SERVER_COUNT: active_servers = cfg_wdata[CFG_COUNT_W-1:0];
          CFG_SERVICE_CAP:  service_cap = cfg_wdata[SVC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (predicted_dispatches.size() == 0) begin
          $error("result transfer with no job outstanding");
          mismatches++;
        end else begin
          want = predicted_dispatches.pop_front();
          check_field("server_index", SUM_W'(want.server_index), SUM_W'(out_server_index));
          check_field("wait_time", SUM_W'(want.wait_time), SUM_W'(out_wait_time));
          check_field("finish_time", SUM_W'(want.finish_time), SUM_W'(out_finish_time));
          check_field("server_jobs", SUM_W'(want.server_jobs), SUM_W'(out_server_jobs));
          check_field("total_wait", want.total_wait, out_total_wait);
          check_field("longest_wait", SUM_W'(want.longest_wait), SUM_W'(out_longest_wait));
          check_field("latest_finish", SUM_W'(want.latest_finish), SUM_W'(out_latest_finish));
          check_field("jobs_so_far", SUM_W'(want.jobs_so_far), SUM_W'(out_jobs_so_far));
          check_field("overflow", SUM_W'(want.overflow), SUM_W'(out_overflow));
        end
      end
      if (in_valid && !in_stall) begin
        predicted_dispatches.push_back(dispatch_job(in_arrival_time, in_service_time));
      end
    end
    dispatches_pending <= predicted_dispatches.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the dispatcher testbench: clock, reset, register writes, job stimulus and verdict.
// Depends on msfd_pkg, multi_server_fcfs_dispatcher and dispatch_checker.
module testbench;
  import msfd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_SERVER_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     in_arrival_time = '0;
  logic [SVC_W-1:0]      in_service_time = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SRV_IDX_W-1:0]  out_server_index;
  logic [TIME_W-1:0]     out_wait_time;
  logic [TIME_W-1:0]     out_finish_time;
  logic [CNT_W-1:0]      out_server_jobs;
  logic [SUM_W-1:0]      out_total_wait;
  logic [TIME_W-1:0]     out_longest_wait;
  logic [TIME_W-1:0]     out_latest_finish;
  logic [CNT_W-1:0]      out_jobs_so_far;
  logic                  out_overflow;

  int          dispatches_pending;
  int          mismatch_count;
  bit          tx_idling = 1'b1;
  bit          rx_idling = 1'b1;
  int unsigned now_min = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  multi_server_fcfs_dispatcher dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_arrival_time(in_arrival_time), .in_service_time(in_service_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_server_index(out_server_index), .out_wait_time(out_wait_time),
    .out_finish_time(out_finish_time), .out_server_jobs(out_server_jobs),
    .out_total_wait(out_total_wait), .out_longest_wait(out_longest_wait),
    .out_latest_finish(out_latest_finish), .out_jobs_so_far(out_jobs_so_far),
    .out_overflow(out_overflow)
  );

  dispatch_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_arrival_time(in_arrival_time), .in_service_time(in_service_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_server_index(out_server_index), .out_wait_time(out_wait_time),
    .out_finish_time(out_finish_time), .out_server_jobs(out_server_jobs),
    .out_total_wait(out_total_wait), .out_longest_wait(out_longest_wait),
    .out_latest_finish(out_latest_finish), .out_jobs_so_far(out_jobs_so_far),
    .out_overflow(out_overflow),
    .dispatches_pending(dispatches_pending), .mismatch_count(mismatch_count)
  );

  // The result side stalls at random while idling is enabled.
  always @(posedge clk) begin
    out_stall <= rx_idling && ($urandom_range(0, 99) < 31);
  end

  // Offers one job and holds it until the transfer. Valid stays high afterwards so a
  // following job can go back to back.
  task automatic send_job(input logic [TIME_W-1:0] arrival, input logic [SVC_W-1:0] request);
    while (tx_idling && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_arrival_time <= arrival;
    in_service_time <= request;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stops offering jobs until every dispatched job has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dispatches_pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes both registers; the unused upper bits of the server count carry random data.
  task automatic set_config(input logic [CFG_COUNT_W-1:0] count,
                            input logic [SVC_W-1:0] cap_value);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_SERVER_COUNT;
    cfg_wdata <= {3'($urandom_range(0, 7)), count};
    @(posedge clk);
    cfg_idx <= CFG_SERVICE_CAP;
    cfg_wdata <= cap_value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly a rising arrival clock with random steps and bursts at one minute; a few jobs
  // arrive out of order. Halfway through the sender holds off until the block drains.
  task automatic run_phase(input int items, input int step_max);
    int k;
    int roll;
    for (k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_job(TIME_W'($urandom_range(0, now_min)), SVC_W'($urandom_range(0, 255)));
      end else begin
        if (roll >= 15) begin
          now_min = now_min + $urandom_range(0, step_max);
        end
        send_job(TIME_W'(now_min), SVC_W'($urandom_range(0, 255)));
      end
      if (k == items / 2) begin
        wait_idle();
      end
    end
  endtask

  initial begin : stimulus
    int p;
    int k;
    int step_max;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one server, cap of 60. A long request is clamped and a later
    // job waits behind the only server.
    send_job(20'd0, 8'd0);
    send_job(20'd0, 8'd255);
    send_job(20'd10, 8'd5);
    wait_idle();

    // Three servers: fill them, then queue on the earliest finish, including a tie
    // and an arrival that goes backwards.
    set_config(5'd3, 8'd255);
    send_job(20'd100, 8'd255);
    send_job(20'd100, 8'd200);
    send_job(20'd100, 8'd100);
    send_job(20'd150, 8'd10);
    send_job(20'd150, 8'd90);
    send_job(20'd160, 8'd1);
    send_job(20'd90, 8'd7);
    send_job(20'd400, 8'd0);
    wait_idle();

    // A server count of zero acts as one; a cap of zero clamps every service to nothing.
    set_config(5'd0, 8'd0);
    send_job(20'd500, 8'd255);
    send_job(20'd400, 8'd3);
    wait_idle();

    // A count above the pool acts as the full pool; a finish equal to the arrival is free.
    set_config(5'd31, 8'd1);
    send_job(20'd600, 8'd255);
    send_job(20'd600, 8'd255);
    send_job(20'd600, 8'd255);
    send_job(20'd600, 8'd255);
    send_job(20'd601, 8'd9);
    wait_idle();

    // Random phases, each under its own setting, the arrival clock moving up between them.
    for (p = 0; p < 6; p++) begin
      wait_idle();
      tx_idling = 1'b1;
      now_min = 700 + p * 130000 + $urandom_range(0, 20000);
      case (p)
        0: begin
          set_config(5'd16, 8'd255);
          step_max = 16;
        end
        1: begin
          set_config(5'd1, 8'd255);
          step_max = 64;
        end
        2: begin
          set_config(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
          step_max = 32;
        end
        3: begin
          set_config(5'($urandom_range(2, 16)), 8'd1);
          step_max = 4;
          tx_idling = 1'b0;
        end
        4: begin
          set_config(5'($urandom_range(17, 31)), 8'($urandom_range(1, 255)));
          step_max = 8;
        end
        default: begin
          set_config(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
          step_max = $urandom_range(1, 64);
        end
      endcase
      run_phase(70, step_max);
    end
    wait_idle();
    tx_idling = 1'b1;

    // Arrivals at the top of the time range: the finish saturates and the flag sets.
    set_config(5'd2, 8'd255);
    send_job(TIME_MAX, 8'd0);
    send_job(TIME_MAX - 20'd10, 8'd255);
    send_job(TIME_MAX, 8'd255);
    send_job(20'd0, 8'd0);
    wait_idle();

    // Long stretch at full rate on one server stuck at the largest time: every job
    // waits nearly the whole time range, so the wait sum climbs quickly.
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    set_config(5'd1, 8'd255);
    for (k = 0; k < 50; k++) begin
      send_job(TIME_W'($urandom_range(0, 1000)), SVC_W'($urandom_range(0, 255)));
    end
    wait_idle();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Guard against a hang: the full run needs well under a tenth of this.
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
